@@ src/tlci_pkg.sv @@
// shared types and constants for the terrain lod crack index generator
`default_nettype none
package tlci_pkg;

   localparam int COL_W      = 6;
   localparam int LOG_W      = 3;
   localparam int CRD_W      = 8;
   localparam int BASE_W     = 15;
   localparam int VERT_W     = 13;
   localparam int CNT_W      = 3;
   localparam int SIDE_W     = 2;
   localparam int PT_W       = 4;
   localparam int NUM_PTS    = 9;
   localparam int NUM_FAN    = 5;
   localparam int NUM_SIDES  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_LOG2 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOD_LEVEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRACK_SIDE = 2'd2;

   localparam logic [LOG_W-1:0] CELLS_LOG2_RESET = 3'd4;
   localparam logic [LOG_W-1:0] LOD_LEVEL_RESET  = 3'd0;
   localparam logic [LOG_W-1:0] CRACK_SIDE_RESET = 3'd0;

   localparam logic [LOG_W-1:0] SIDE_LEFT   = 3'd1;
   localparam logic [LOG_W-1:0] SIDE_TOP    = 3'd2;
   localparam logic [LOG_W-1:0] SIDE_RIGHT  = 3'd3;
   localparam logic [LOG_W-1:0] SIDE_BOTTOM = 3'd4;

   localparam logic [CNT_W-1:0] TRI_FIRST     = 3'd0;
   localparam logic [CNT_W-1:0] TRI_FAN_LAST  = 3'd4;

   localparam logic [PT_W-1:0] P0 = 4'd0;
   localparam logic [PT_W-1:0] P1 = 4'd1;
   localparam logic [PT_W-1:0] P2 = 4'd2;
   localparam logic [PT_W-1:0] P3 = 4'd3;
   localparam logic [PT_W-1:0] P4 = 4'd4;
   localparam logic [PT_W-1:0] P5 = 4'd5;
   localparam logic [PT_W-1:0] P6 = 4'd6;
   localparam logic [PT_W-1:0] P7 = 4'd7;
   localparam logic [PT_W-1:0] P8 = 4'd8;

   // fan corners b and c per side (left, top, right, bottom); corner a is the centre
   localparam logic [PT_W-1:0] FAN_B [NUM_SIDES][NUM_FAN] = '{
      '{P0, P2, P8, P6, P3},
      '{P0, P1, P2, P8, P6},
      '{P0, P2, P5, P8, P6},
      '{P0, P2, P8, P7, P6}
   };
   localparam logic [PT_W-1:0] FAN_C [NUM_SIDES][NUM_FAN] = '{
      '{P2, P8, P6, P3, P0},
      '{P1, P2, P8, P6, P0},
      '{P2, P5, P8, P6, P0},
      '{P2, P8, P7, P6, P0}
   };

   typedef struct packed {
      logic [COL_W-1:0] block_col;
      logic [COL_W-1:0] block_row;
   } req_type;

   typedef struct packed {
      logic [VERT_W-1:0] vert_a;
      logic [VERT_W-1:0] vert_b;
      logic [VERT_W-1:0] vert_c;
      logic              last_tri;
      logic              bad_coord;
   } rsp_type;

   typedef struct packed {
      logic [LOG_W-1:0] cells_log2;
      logic [LOG_W-1:0] lod_level;
      logic [LOG_W-1:0] crack_side;
   } cfg_type;

   typedef struct packed {
      logic              bad;
      logic              fan;
      logic [SIDE_W-1:0] side_idx;
   } ctl_type;

   typedef struct packed {
      ctl_type          ctl;
      logic [LOG_W-1:0] cl;
      logic [CRD_W-1:0] half;
      logic [CRD_W-1:0] x;
      logic [CRD_W-1:0] z;
   } blk_type;

   typedef logic [NUM_PTS-1:0][VERT_W-1:0] pts_type;

   typedef struct packed {
      ctl_type ctl;
      pts_type pts;
   } em_type;

endpackage
`default_nettype wire

@@ src/tlci_param.sv @@
// first stage: effective tile size and level, range check, crack decision, block origin
`default_nettype none
module tlci_param #(
   parameter int MAX_CELLS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tlci_pkg::cfg_type cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire tlci_pkg::req_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output tlci_pkg::blk_type      out_data
);
   import tlci_pkg::*;

   localparam int MAX_LOG2 = $clog2(MAX_CELLS + 1) - 1;

   logic [LOG_W-1:0] cl_eff;
   logic [LOG_W-1:0] lv_eff;
   logic [CRD_W-1:0] cells;
   logic [CRD_W-1:0] count;
   logic [CRD_W-1:0] last_idx;
   logic [CRD_W-1:0] col_w;
   logic [CRD_W-1:0] row_w;
   logic             fan_side;
   logic             valid_ff;
   logic             valid_in;
   blk_type          blk_ff;
   blk_type          blk_in;

   always_comb begin
      cl_eff = (cfg.cells_log2 > LOG_W'(MAX_LOG2)) ? LOG_W'(MAX_LOG2) : cfg.cells_log2;
      if (({1'b0, cfg.lod_level} + 4'd1) > {1'b0, cl_eff}) begin
         lv_eff = (cl_eff != '0) ? cl_eff - 3'd1 : '0;
      end else begin
         lv_eff = cfg.lod_level;
      end
      cells    = CRD_W'(1) << cl_eff;
      count    = cells >> lv_eff;
      last_idx = count - CRD_W'(1);
      col_w    = CRD_W'(in_data.block_col);
      row_w    = CRD_W'(in_data.block_row);
      case (cfg.crack_side)
         SIDE_LEFT:   fan_side = (col_w == '0);
         SIDE_TOP:    fan_side = (row_w == '0);
         SIDE_RIGHT:  fan_side = (col_w == last_idx);
         SIDE_BOTTOM: fan_side = (row_w == last_idx);
         default:     fan_side = 1'b0;
      endcase
      blk_in.ctl.bad      = (col_w >= count) || (row_w >= count);
      blk_in.ctl.fan      = fan_side && (lv_eff != '0);
      blk_in.ctl.side_idx = SIDE_W'(cfg.crack_side - 3'd1);
      blk_in.cl           = cl_eff;
      blk_in.half         = (CRD_W'(1) << lv_eff) >> 1;
      blk_in.x            = col_w << lv_eff;
      blk_in.z            = row_w << lv_eff;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = blk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         blk_ff <= blk_in;
      end
   end

endmodule
`default_nettype wire

@@ src/tlci_addr.sv @@
// three stages of vertex index arithmetic: rows and columns, row bases, nine points
`default_nettype none
module tlci_addr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire tlci_pkg::blk_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output tlci_pkg::em_type       out_data
);
   import tlci_pkg::*;

   logic                 v2_ff;
   logic                 v3_ff;
   logic                 v4_ff;
   logic                 rdy2;
   logic                 rdy3;
   logic                 rdy4;
   ctl_type              ctl2_ff;
   ctl_type              ctl3_ff;
   logic [LOG_W-1:0]     cl2_ff;
   logic [CRD_W-1:0]     row2_ff [3];
   logic [CRD_W-1:0]     col2_ff [3];
   logic [CRD_W-1:0]     col3_ff [3];
   logic [BASE_W-1:0]    base3_ff [3];
   logic [CRD_W-1:0]     row2_in [3];
   logic [CRD_W-1:0]     col2_in [3];
   logic [BASE_W-1:0]    base3_in [3];
   em_type               em4_ff;
   em_type               em4_in;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = rdy2;

   always_comb begin
      row2_in[0] = in_data.z;
      row2_in[1] = in_data.z + in_data.half;
      row2_in[2] = in_data.z + (in_data.half << 1);
      col2_in[0] = in_data.x;
      col2_in[1] = in_data.x + in_data.half;
      col2_in[2] = in_data.x + (in_data.half << 1);
      for (int k = 0; k < 3; k++) begin
         base3_in[k] = (BASE_W'(row2_ff[k]) << cl2_ff) + BASE_W'(row2_ff[k]);
      end
      em4_in.ctl = ctl3_ff;
      for (int dz = 0; dz < 3; dz++) begin
         for (int dx = 0; dx < 3; dx++) begin
            em4_in.pts[dz * 3 + dx] = VERT_W'(base3_ff[dz] + BASE_W'(col3_ff[dx]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy2) begin
            v2_ff <= in_valid;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
      if (in_valid && rdy2) begin
         ctl2_ff <= in_data.ctl;
         cl2_ff  <= in_data.cl;
         row2_ff <= row2_in;
         col2_ff <= col2_in;
      end
      if (v2_ff && rdy3) begin
         ctl3_ff  <= ctl2_ff;
         col3_ff  <= col2_ff;
         base3_ff <= base3_in;
      end
      if (v3_ff && rdy4) begin
         em4_ff <= em4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = em4_ff;

endmodule
`default_nettype wire

@@ src/tlci_emit.sv @@
// triangle sequencer and output register
`default_nettype none
module tlci_emit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire tlci_pkg::em_type in_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tlci_pkg::rsp_type     rsp_data
);
   import tlci_pkg::*;

   logic             em_valid_ff;
   em_type           em_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             out_valid_ff;
   rsp_type          out_ff;
   rsp_type          tri_data;
   logic             out_load;
   logic             em_load;

   always_comb begin
      tri_data = '0;
      if (em_ff.ctl.bad) begin
         tri_data.last_tri  = 1'b1;
         tri_data.bad_coord = 1'b1;
      end else if (em_ff.ctl.fan) begin
         tri_data.vert_a   = em_ff.pts[P4];
         tri_data.vert_b   = em_ff.pts[FAN_B[em_ff.ctl.side_idx][cnt_ff]];
         tri_data.vert_c   = em_ff.pts[FAN_C[em_ff.ctl.side_idx][cnt_ff]];
         tri_data.last_tri = (cnt_ff == TRI_FAN_LAST);
      end else if (cnt_ff == TRI_FIRST) begin
         tri_data.vert_a = em_ff.pts[P0];
         tri_data.vert_b = em_ff.pts[P2];
         tri_data.vert_c = em_ff.pts[P6];
      end else begin
         tri_data.vert_a   = em_ff.pts[P6];
         tri_data.vert_b   = em_ff.pts[P2];
         tri_data.vert_c   = em_ff.pts[P8];
         tri_data.last_tri = 1'b1;
      end
   end

   assign out_load = em_valid_ff && (!out_valid_ff || rsp_ready);
   assign in_ready = !em_valid_ff || (out_load && tri_data.last_tri);
   assign em_load  = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff  <= 1'b0;
         cnt_ff       <= TRI_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         if (em_load) begin
            em_valid_ff <= 1'b1;
            cnt_ff      <= TRI_FIRST;
         end else if (out_load && tri_data.last_tri) begin
            em_valid_ff <= 1'b0;
         end else if (out_load) begin
            cnt_ff <= cnt_ff + 3'd1;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (em_load) begin
         em_ff <= in_data;
      end
      if (out_load) begin
         out_ff <= tri_data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      em_valid_ff |-> (cnt_ff <= TRI_FAN_LAST))
      else $error("triangle count out of range");

   a_basic_two: assert property (@(posedge clock) disable iff (reset)
      (em_valid_ff && !em_ff.ctl.fan && !em_ff.ctl.bad) |-> (cnt_ff <= 3'd1))
      else $error("basic block beyond two triangles");

   a_bad_single: assert property (@(posedge clock) disable iff (reset)
      (em_valid_ff && em_ff.ctl.bad) |-> (cnt_ff == TRI_FIRST))
      else $error("bad block beyond one result");

   a_bad_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.bad_coord) |->
         (out_ff.last_tri && out_ff.vert_a == '0 && out_ff.vert_b == '0
          && out_ff.vert_c == '0))
      else $error("bad result not a zero final item");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> out_valid_ff)
      else $error("output item dropped while stalled");

endmodule
`default_nettype wire

@@ src/terrain_lod_crack_index_gen_core.sv @@
// top level of the terrain lod crack index generator
//
// req channel: one item names a block of the tile by column and row in step
// units. rsp channel: the block's triangles, one item each, as three vertex
// indices into the (cells+1)^2 grid; last_tri marks the block's final item.
// a basic block gives two items, a crack fan gives five, an out of range
// coordinate gives one item with bad_coord and zero vertices.
// csr port: csr_we writes csr_wdata to register csr_index (cells_log2,
// lod_level, crack_side) at once; write only while no item is in flight.
// path: the first item of a block reaches rsp through the param stage, three
// address stages, the sequencer and the output register.
// throughput: blocks enter the pipeline one per cycle while it is not stalled;
// the sequencer emits one triangle per cycle while rsp_ready is high, so a basic
// block gives two items at the output, a fan block five and a bad block one.
// reset clears the configuration to its reset values and empties the pipe.
// when rsp_ready is low the output register holds its item and stages fill
// up behind it; req_ready drops once all are full, nothing is lost.
`default_nettype none
module terrain_lod_crack_index_gen_core #(
   parameter int MAX_CELLS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire tlci_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output tlci_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [tlci_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tlci_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tlci_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    blk_valid;
   logic    blk_ready;
   blk_type blk_data;
   logic    em_valid;
   logic    em_ready;
   em_type  em_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CELLS_LOG2: cfg_in.cells_log2 = csr_wdata;
            CSR_LOD_LEVEL:  cfg_in.lod_level  = csr_wdata;
            CSR_CRACK_SIDE: cfg_in.crack_side = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cells_log2 <= CELLS_LOG2_RESET;
         cfg_ff.lod_level  <= LOD_LEVEL_RESET;
         cfg_ff.crack_side <= CRACK_SIDE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tlci_param #(
      .MAX_CELLS (MAX_CELLS)
   ) u_param (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (blk_valid),
      .out_ready (blk_ready),
      .out_data  (blk_data)
   );

   tlci_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (blk_valid),
      .in_ready  (blk_ready),
      .in_data   (blk_data),
      .out_valid (em_valid),
      .out_ready (em_ready),
      .out_data  (em_data)
   );

   tlci_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (em_valid),
      .in_ready  (em_ready),
      .in_data   (em_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
